// ===== sv/sri_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the segment versus rectangle test.
package sri_pkg;

	localparam int CoordBitsDef = 12;
	localparam int NumCorners   = 4;
	localparam int NumEdges     = 4;

	// Per-item flags worked out in the first stage.
	typedef struct packed {
		logic                in_rect;  // an endpoint lies in the rectangle
		logic [NumEdges-1:0] edge_ok;  // boxes overlap and the segment straddles the edge's line
	} flags_t;

	// Signs of the segment turn toward each rectangle corner.
	typedef struct packed {
		logic [NumCorners-1:0] pos;
		logic [NumCorners-1:0] neg;
	} turn_t;

endpackage

// ===== sv/sri_prep.sv =====
`timescale 1ns / 1ps
// First stage: coordinate differences, inside test, bounding boxes and edge-side checks.
module sri_prep #(
	parameter int COORD_BITS = sri_pkg::CoordBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COORD_BITS-1:0]  seg_ax,
	input  logic [COORD_BITS-1:0]  seg_ay,
	input  logic [COORD_BITS-1:0]  seg_bx,
	input  logic [COORD_BITS-1:0]  seg_by,
	input  logic [COORD_BITS-1:0]  rect_left,
	input  logic [COORD_BITS-1:0]  rect_bottom,
	input  logic [COORD_BITS-1:0]  rect_right,
	input  logic [COORD_BITS-1:0]  rect_top,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [COORD_BITS:0] dx_s1,
	output logic signed [COORD_BITS:0] dy_s1,
	output logic signed [COORD_BITS:0] lx_s1,
	output logic signed [COORD_BITS:0] rx_s1,
	output logic signed [COORD_BITS:0] by_s1,
	output logic signed [COORD_BITS:0] ty_s1,
	output sri_pkg::flags_t            flags_s1
);

	localparam int NE = sri_pkg::NumEdges;

	logic                  valid_s1;
	logic                  adv;
	logic                  in_a, in_b;
	logic [COORD_BITS-1:0] s_xmn, s_xmx, s_ymn, s_ymx;
	logic [COORD_BITS-1:0] r_xmn, r_xmx, r_ymn, r_ymx;
	logic [COORD_BITS-1:0] e_xlo [NE];
	logic [COORD_BITS-1:0] e_xhi [NE];
	logic [COORD_BITS-1:0] e_ylo [NE];
	logic [COORD_BITS-1:0] e_yhi [NE];
	logic [NE-1:0]         bbox_ok;
	logic [NE-1:0]         side_ok;
	sri_pkg::flags_t       flags_d;

	// Not both strictly above and not both strictly below the line at v.
	function automatic logic straddle(input logic [COORD_BITS-1:0] p,
		input logic [COORD_BITS-1:0] q, input logic [COORD_BITS-1:0] v);
		straddle = !((p > v && q > v) || (p < v && q < v));
	endfunction

	function automatic logic signed [COORD_BITS:0] diff(input logic [COORD_BITS-1:0] p,
		input logic [COORD_BITS-1:0] q);
		diff = $signed({1'b0, p}) - $signed({1'b0, q});
	endfunction

	assign adv      = !valid_s1 || out_ready;
	assign in_ready = adv;
	assign out_valid = valid_s1;

	always_comb begin
		in_a = seg_ax >= rect_left && seg_ax <= rect_right &&
			seg_ay >= rect_bottom && seg_ay <= rect_top;
		in_b = seg_bx >= rect_left && seg_bx <= rect_right &&
			seg_by >= rect_bottom && seg_by <= rect_top;

		s_xmn = (seg_ax < seg_bx) ? seg_ax : seg_bx;
		s_xmx = (seg_ax > seg_bx) ? seg_ax : seg_bx;
		s_ymn = (seg_ay < seg_by) ? seg_ay : seg_by;
		s_ymx = (seg_ay > seg_by) ? seg_ay : seg_by;
		r_xmn = (rect_left < rect_right) ? rect_left : rect_right;
		r_xmx = (rect_left > rect_right) ? rect_left : rect_right;
		r_ymn = (rect_bottom < rect_top) ? rect_bottom : rect_top;
		r_ymx = (rect_bottom > rect_top) ? rect_bottom : rect_top;

		// Edges: left, top, right, bottom, each from one corner to the next.
		e_xlo[0] = rect_left;  e_xhi[0] = rect_left;  e_ylo[0] = r_ymn;    e_yhi[0] = r_ymx;
		e_xlo[1] = r_xmn;      e_xhi[1] = r_xmx;      e_ylo[1] = rect_top; e_yhi[1] = rect_top;
		e_xlo[2] = rect_right; e_xhi[2] = rect_right; e_ylo[2] = r_ymn;    e_yhi[2] = r_ymx;
		e_xlo[3] = r_xmn;      e_xhi[3] = r_xmx;      e_ylo[3] = rect_bottom;
		e_yhi[3] = rect_bottom;

		for (int e = 0; e < NE; e++) begin
			bbox_ok[e] = !(s_xmx < e_xlo[e] || e_xhi[e] < s_xmn ||
				s_ymx < e_ylo[e] || e_yhi[e] < s_ymn);
		end

		// A degenerate edge always passes the side check.
		side_ok[0] = (rect_top == rect_bottom) || straddle(seg_ax, seg_bx, rect_left);
		side_ok[1] = (rect_right == rect_left) || straddle(seg_ay, seg_by, rect_top);
		side_ok[2] = (rect_top == rect_bottom) || straddle(seg_ax, seg_bx, rect_right);
		side_ok[3] = (rect_right == rect_left) || straddle(seg_ay, seg_by, rect_bottom);

		flags_d.in_rect = in_a || in_b;
		flags_d.edge_ok = bbox_ok & side_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			dx_s1    <= diff(seg_bx, seg_ax);
			dy_s1    <= diff(seg_by, seg_ay);
			lx_s1    <= diff(rect_left, seg_ax);
			rx_s1    <= diff(rect_right, seg_ax);
			by_s1    <= diff(rect_bottom, seg_ay);
			ty_s1    <= diff(rect_top, seg_ay);
			flags_s1 <= flags_d;
		end
	end

endmodule

// ===== sv/sri_cross.sv =====
`timescale 1ns / 1ps
// Second and third stages: the four products, then the corner cross-product signs.
module sri_cross #(
	parameter int COORD_BITS = sri_pkg::CoordBitsDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [COORD_BITS:0] dx_s1,
	input  logic signed [COORD_BITS:0] dy_s1,
	input  logic signed [COORD_BITS:0] lx_s1,
	input  logic signed [COORD_BITS:0] rx_s1,
	input  logic signed [COORD_BITS:0] by_s1,
	input  logic signed [COORD_BITS:0] ty_s1,
	input  sri_pkg::flags_t            flags_s1,
	output logic                       out_valid,
	input  logic                       out_ready,
	output sri_pkg::turn_t             turn_s3,
	output sri_pkg::flags_t            flags_s3
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int NC = sri_pkg::NumCorners;

	logic                 valid_s2, valid_s3;
	logic                 adv2, adv3;
	logic signed [PW-1:0] p_bot_s2, p_top_s2, q_l_s2, q_r_s2;
	sri_pkg::flags_t      flags_s2;
	logic signed [XW-1:0] cr [NC];
	sri_pkg::turn_t       turn_d;

	assign adv3      = !valid_s3 || out_ready;
	assign adv2      = !valid_s2 || adv3;
	assign in_ready  = adv2;
	assign out_valid = valid_s3;

	// Corners in order: lower-left, upper-left, upper-right, lower-right.
	always_comb begin
		cr[0] = XW'(p_bot_s2) - XW'(q_l_s2);
		cr[1] = XW'(p_top_s2) - XW'(q_l_s2);
		cr[2] = XW'(p_top_s2) - XW'(q_r_s2);
		cr[3] = XW'(p_bot_s2) - XW'(q_r_s2);
		for (int k = 0; k < NC; k++) begin
			turn_d.neg[k] = cr[k][XW-1];
			turn_d.pos[k] = !cr[k][XW-1] && (cr[k] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2 <= in_valid;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && in_valid) begin
			p_bot_s2 <= dx_s1 * by_s1;
			p_top_s2 <= dx_s1 * ty_s1;
			q_l_s2   <= lx_s1 * dy_s1;
			q_r_s2   <= rx_s1 * dy_s1;
			flags_s2 <= flags_s1;
		end
		if (adv3 && valid_s2) begin
			turn_s3  <= turn_d;
			flags_s3 <= flags_s2;
		end
	end

endmodule

// ===== sv/sri_decide.sv =====
`timescale 1ns / 1ps
// Output stage: combine edge tests into the final answer and hold it for the receiver.
module sri_decide (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sri_pkg::turn_t  turn_s3,
	input  sri_pkg::flags_t flags_s3,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            visible
);

	localparam int NE = sri_pkg::NumEdges;
	localparam int NC = sri_pkg::NumCorners;

	logic          valid_s4;
	logic          visible_s4;
	logic          adv;
	logic [NE-1:0] meet;
	logic          hit;

	assign adv       = !valid_s4 || out_ready;
	assign in_ready  = adv;
	assign out_valid = valid_s4;
	assign visible   = visible_s4;

	// Edge e runs from corner e to the next corner; its ends must not lie on one side.
	always_comb begin
		for (int e = 0; e < NE; e++) begin
			meet[e] = flags_s3.edge_ok[e] &&
				!((turn_s3.pos[e] && turn_s3.pos[(e + 1) % NC]) ||
				  (turn_s3.neg[e] && turn_s3.neg[(e + 1) % NC]));
		end
		hit = flags_s3.in_rect || (|meet);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			visible_s4 <= hit;
		end
	end

endmodule

// ===== sv/segment_rect_intersect_top.sv =====
`timescale 1ns / 1ps
// Segment versus axis-aligned rectangle test: four-stage pipeline.
//
// Input channel (in_valid / in_ready) carries one segment (seg_ax, seg_ay,
// seg_bx, seg_by) and one rectangle (lower-left rect_left/rect_bottom, upper-
// right rect_right/rect_top) per beat. Output channel (out_valid / out_ready)
// returns one beat with visible = 1 when the closed segment touches or crosses
// the closed rectangle.
// Throughput: one beat per cycle when the receiver takes every beat; four
// items are in flight at once.
// Stages: coordinate differences and compares, four 13x13 products, corner
// cross-product signs, final combine into the output register.
// Reset (arst_n low) empties all stages at once; no results are pending after.
// When the receiver holds out_ready low, the output beat is held and stages
// behind it keep filling until every stage is full; in_ready then drops, and
// no beat is lost or duplicated.
module segment_rect_intersect_top #(
	parameter int COORD_BITS = sri_pkg::CoordBitsDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] seg_ax,
	input  logic [COORD_BITS-1:0] seg_ay,
	input  logic [COORD_BITS-1:0] seg_bx,
	input  logic [COORD_BITS-1:0] seg_by,
	input  logic [COORD_BITS-1:0] rect_left,
	input  logic [COORD_BITS-1:0] rect_bottom,
	input  logic [COORD_BITS-1:0] rect_right,
	input  logic [COORD_BITS-1:0] rect_top,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  visible
);

	logic                       v1, r1, v3, r3;
	logic signed [COORD_BITS:0] dx_s1, dy_s1, lx_s1, rx_s1, by_s1, ty_s1;
	sri_pkg::flags_t            flags_s1, flags_s3;
	sri_pkg::turn_t             turn_s3;

	sri_prep #(.COORD_BITS(COORD_BITS)) u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.seg_ax      (seg_ax),
		.seg_ay      (seg_ay),
		.seg_bx      (seg_bx),
		.seg_by      (seg_by),
		.rect_left   (rect_left),
		.rect_bottom (rect_bottom),
		.rect_right  (rect_right),
		.rect_top    (rect_top),
		.out_valid   (v1),
		.out_ready   (r1),
		.dx_s1       (dx_s1),
		.dy_s1       (dy_s1),
		.lx_s1       (lx_s1),
		.rx_s1       (rx_s1),
		.by_s1       (by_s1),
		.ty_s1       (ty_s1),
		.flags_s1    (flags_s1)
	);

	sri_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.dx_s1     (dx_s1),
		.dy_s1     (dy_s1),
		.lx_s1     (lx_s1),
		.rx_s1     (rx_s1),
		.by_s1     (by_s1),
		.ty_s1     (ty_s1),
		.flags_s1  (flags_s1),
		.out_valid (v3),
		.out_ready (r3),
		.turn_s3   (turn_s3),
		.flags_s3  (flags_s3)
	);

	sri_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v3),
		.in_ready  (r3),
		.turn_s3   (turn_s3),
		.flags_s3  (flags_s3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.visible   (visible)
	);

endmodule

// ===== sv/sri_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the segment versus rectangle test, bound to the top level.
module sri_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic visible
);

	// Hold a stalled output beat.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(visible))
		else $error("output beat changed while stalled");

	// Reset empties the pipeline at once.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// A free-running receiver never throttles the input.
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while receiver is ready");

	// Accepted beat reaches the output when the receiver does not stall.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("accepted beat did not arrive at the output");

endmodule

bind segment_rect_intersect_top sri_checker u_sri_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.visible   (visible)
);
